// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// Concurrent assertion wrappers with a common clock and reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset
`define SPQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `SPQ_ASSERT(label, clk, rst, !(expr), msg)

`endif

// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Depth, field widths, request and status codes, and the entry type.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;
   localparam int FIELD_W     = 32;

   // Beat layouts
   localparam int REQ_DATA_W  = 2 * FIELD_W;
   localparam int RSP_FIELDS_W = 2 * FIELD_W + OCC_W;
   localparam int RSP_DATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELDS_W;
   localparam int RSP_OCC_LSB = 2 * FIELD_W;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_POP    = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] prio;
      logic signed [FIELD_W-1:0] value;
   } entry_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic pop_en;
   } cell_ctrl_type;

endpackage

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert it keeps, takes the new entry or shifts from
// its lower neighbor; on pop it takes its upper neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   prev_le,
   input  spq_pkg::entry_type     new_entry,
   input  spq_pkg::entry_type     prev_entry,
   input  spq_pkg::entry_type     next_entry,
   output spq_pkg::entry_type     entry,
   output logic                   le
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Stored entry stays ahead of the new one when its priority is not larger
   assign le = occupied && (entry_ff.prio <= new_entry.prio);

   // Select next content
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (le) begin
            entry_in = entry_ff;
         end else if (prev_le) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctrl.pop_en) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue
// Bounded min-first queue built from a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one beat per request. tuser[0] selects insert (0) or pop (1);
//   tdata carries the value and priority of an insert, ignored for pop.
//   rsp channel: one beat per request, in request order. tuser carries the
//   status (ok, underflow on empty pop, overflow on full insert); tdata
//   carries the popped value and priority (zero unless a pop succeeded) and
//   the occupancy after the request.
//   The response is registered and presented in the cycle after the request beat.
//   Throughput: one request per cycle unless the response is stalled. Every
//   cell compares its priority with the incoming one in parallel and shifts
//   in the same cycle, so the cell row is done with each request before the next.
//   Equal priorities leave in arrival order. Entries are held sorted, so
//   the head cell is always the entry to pop.
//   Reset clears the entry count and the response valid flag; the queue is
//   empty and ready in the first cycle after reset.
//   A stalled response holds its beat; one new request is still taken in
//   the cycle the held beat is consumed, else req_tready stays low.
// ---------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [spq_pkg::REQ_DATA_W-1:0]  req_tdata,  // item_value, item_priority
   input  logic [0:0]                      req_tuser,  // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spq_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // popped_value, popped_priority,
                                                       // occupancy, zero pad
   output logic [1:0]                      rsp_tuser   // status
);
   import spq_pkg::*;

   logic                  req_fire;
   req_kind_type          req_kind;
   entry_type             new_entry;
   logic                  is_full;
   logic                  is_empty;
   cell_ctrl_type         cell_ctrl;

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            status_ff;
   status_type            status_in;
   entry_type             popped_ff;
   entry_type             popped_in;
   logic [OCC_W-1:0]      occ_ff;
   logic [OCC_W-1:0]      occ_in;

   entry_type             cell_q  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_le;

   // Request decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = req_kind_type'(req_tuser[0]);
   assign new_entry.value = req_tdata[FIELD_W-1:0];
   assign new_entry.prio  = req_tdata[2*FIELD_W-1:FIELD_W];
   assign is_full    = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign is_empty   = (count_ff == '0);

   // Command to the cell row and next count, status and result
   always_comb begin
      cell_ctrl    = '0;
      count_in     = count_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         popped_in    = '0;
         case (req_kind)
            REQ_INSERT: begin
               if (is_full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  cell_ctrl.insert_en = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            REQ_POP: begin
               if (is_empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  cell_ctrl.pop_en = 1'b1;
                  popped_in = cell_q[0];
                  count_in  = count_ff - COUNT_W'(1);
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
         occ_in = OCC_W'(count_in);
      end
   end

   // Cell row: cell 0 is the head
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      prev_le_w;
      entry_type prev_w;
      entry_type next_w;
      logic      occupied_w;

      assign occupied_w = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_le_w = 1'b1;
         assign prev_w    = new_entry;
      end else begin : g_body
         assign prev_le_w = cell_le[i-1];
         assign prev_w    = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_w = cell_q[i];
      end else begin : g_mid
         assign next_w = cell_q[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .occupied   (occupied_w),
         .prev_le    (prev_le_w),
         .new_entry  (new_entry),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .entry      (cell_q[i]),
         .le         (cell_le[i])
      );
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, held while stalled
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
      occ_ff    <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, occ_ff, popped_ff.prio, popped_ff.value};

endmodule

// ===== src/spq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the request and response beats on the top-level ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [spq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser
);
   import spq_pkg::*;

   logic             req_beat;
   logic [OCC_W-1:0] rsp_occ;
   logic             rsp_underflow;
   logic             rsp_overflow;

   assign req_beat      = req_tvalid && req_tready;
   assign rsp_occ       = rsp_tdata[RSP_OCC_LSB +: OCC_W];
   assign rsp_underflow = (rsp_tuser == STATUS_UNDERFLOW);
   assign rsp_overflow  = (rsp_tuser == STATUS_OVERFLOW);

   // Held response beat keeps its contents
   `SPQ_ASSERT(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)),
      "response beat changed while stalled")

   // Every request beat yields a response in the next cycle
   `SPQ_ASSERT(a_req_to_rsp, clock, reset,
      req_beat |=> rsp_tvalid,
      "request beat without response")

   // Underflow only on an empty queue, with zero payload
   `SPQ_ASSERT(a_underflow_empty, clock, reset,
      (rsp_tvalid && rsp_underflow) |-> (rsp_occ == '0 && rsp_tdata[2*FIELD_W-1:0] == '0),
      "underflow with nonzero payload or occupancy")

   // Overflow only on a full queue, and occupancy never beyond depth
   `SPQ_ASSERT(a_overflow_full, clock, reset,
      (rsp_tvalid && rsp_overflow) |-> (rsp_occ == OCC_W'(QUEUE_DEPTH)),
      "overflow reported on a queue that is not full")

   `SPQ_ASSERT_NEVER(a_occ_range, clock, reset,
      rsp_tvalid && (rsp_occ > OCC_W'(QUEUE_DEPTH)),
      "occupancy beyond queue depth")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
